>>> src/hptc_pkg.sv
package hptc_pkg;

  // Fixed-point arithmetic settings.
  localparam int INTEGRAL_WIDTH = 24;
  localparam int GAIN_FRAC_BITS = 16;

  // Field widths.
  localparam int GAIN_W     = 24;
  localparam int MAXD_W     = 7;
  localparam int BAND_W     = 8;
  localparam int SETTLE_W   = 4;
  localparam int TMO_W      = 8;
  localparam int WARM_W     = 2;
  localparam int GYRO_W     = 16;
  localparam int TARGET_W   = 10;
  localparam int DRIVE_W    = 8;
  localparam int ERR_W      = 10;
  localparam int DERIV_W    = 11;
  localparam int HEADING_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Heading wrap: the gyro count is offset by a multiple of 360 so that it is
  // never negative, then reduced with a reciprocal multiply.
  localparam int UOFS_W      = GYRO_W + 1;
  localparam int GYRO_OFS    = 33120;
  localparam int RECIP       = 93207;
  localparam int RECIP_SHIFT = 25;
  localparam int QUOT_W      = 8;

  // The integral term is multiplied as two partial products.
  localparam int INT_LO_W = INTEGRAL_WIDTH / 2;
  localparam int INT_HI_W = INTEGRAL_WIDTH - INT_LO_W;
  localparam int P_ERR_W  = GAIN_W + 1 + ERR_W;
  localparam int P_DER_W  = GAIN_W + 1 + DERIV_W;
  localparam int P_LO_W   = GAIN_W + 1 + INT_LO_W + 1;
  localparam int P_HI_W   = GAIN_W + 1 + INT_HI_W;
  localparam int SUM_W    = INTEGRAL_WIDTH + GAIN_W + 4;
  localparam int QUO_W    = SUM_W - GAIN_FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_GAIN       = 3'd0,
    CFG_KI_GAIN       = 3'd1,
    CFG_KD_GAIN       = 3'd2,
    CFG_MAX_DRIVE     = 3'd3,
    CFG_SETTLE_BAND   = 3'd4,
    CFG_SETTLE_TICKS  = 3'd5,
    CFG_TIMEOUT_TICKS = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic zero_drive;
    logic done;
  } res_ctrl_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]          err;
    logic signed [DERIV_W-1:0]        deriv;
    logic signed [INTEGRAL_WIDTH-1:0] integ;
  } pid_operands_t;

endpackage

>>> src/hptc_if.sv
interface hptc_in_if;
  import hptc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic signed [GYRO_W-1:0]   raw_gyro;
  logic signed [TARGET_W-1:0] target_heading;
  modport source (output valid, action, raw_gyro, target_heading, input ready);
  modport sink (input valid, action, raw_gyro, target_heading, output ready);
endinterface

interface hptc_out_if;
  import hptc_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [DRIVE_W-1:0] left_drive;
  logic signed [DRIVE_W-1:0] right_drive;
  logic                      done_res;
  modport source (output valid, left_drive, right_drive, done_res, input ready);
  modport sink (input valid, left_drive, right_drive, done_res, output ready);
endinterface

interface hptc_cfg_if;
  import hptc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/hptc_pid_datapath.sv
module hptc_pid_datapath (
  input  logic                          clk,
  input  logic                          load,
  input  hptc_pkg::pid_operands_t       ops,
  input  logic [hptc_pkg::GAIN_W-1:0]   kp_gain,
  input  logic [hptc_pkg::GAIN_W-1:0]   ki_gain,
  input  logic [hptc_pkg::GAIN_W-1:0]   kd_gain,
  input  logic [hptc_pkg::MAXD_W-1:0]   max_drive,
  output logic signed [hptc_pkg::DRIVE_W-1:0] drive
);
  import hptc_pkg::*;

  logic signed [P_ERR_W-1:0] p_err_r;
  logic signed [P_DER_W-1:0] p_der_r;
  logic signed [P_LO_W-1:0]  p_lo_r;
  logic signed [P_HI_W-1:0]  p_hi_r;

  logic signed [SUM_W-1:0] sum;
  logic signed [QUO_W-1:0] quo;
  logic signed [QUO_W-1:0] quo_tz;
  logic signed [QUO_W-1:0] lim;
  logic signed [QUO_W-1:0] neg_lim;
  logic signed [QUO_W-1:0] clamped;
  logic                    round_up;

  // Product stage: the integral is split into an unsigned low half and a
  // signed high half so that no single multiplier gets too wide.
  always_ff @(posedge clk) begin
    if (load) begin
      p_err_r <= $signed({1'b0, kp_gain}) * ops.err;
      p_der_r <= $signed({1'b0, kd_gain}) * ops.deriv;
      p_lo_r  <= $signed({1'b0, ki_gain}) * $signed({1'b0, ops.integ[INT_LO_W-1:0]});
      p_hi_r  <= $signed({1'b0, ki_gain}) * $signed(ops.integ[INTEGRAL_WIDTH-1:INT_LO_W]);
    end
  end

  // Sum, truncate toward zero, clamp.
  always_comb begin
    sum = SUM_W'(p_err_r) + SUM_W'(p_der_r) + (SUM_W'(p_hi_r) <<< INT_LO_W)
          + SUM_W'(p_lo_r);
    quo      = sum[SUM_W-1:GAIN_FRAC_BITS];
    round_up = sum[SUM_W-1] && (|sum[GAIN_FRAC_BITS-1:0]);
    quo_tz   = quo + $signed({{(QUO_W-1){1'b0}}, round_up});
    lim      = $signed({{(QUO_W-MAXD_W){1'b0}}, max_drive});
    neg_lim  = -lim;
    if (quo_tz > lim) begin
      clamped = lim;
    end else if (quo_tz < neg_lim) begin
      clamped = neg_lim;
    end else begin
      clamped = quo_tz;
    end
    drive = clamped[DRIVE_W-1:0];
  end

endmodule

>>> src/heading_pid_turn_controller_unit.sv
// Pipeline: five pipeline registers (stages A, B, C, D and the output register)
// lie between an input transaction and its result on the out channel.
// Throughput: one transaction per cycle while the out channel is not stalled;
// the turn state sits in a single stage whose feedback closes within it, so items follow back to back.
// Reset: rst_n is synchronous and active low; it clears all pipeline valid
// bits and the turn state, and loads the register defaults.
module heading_pid_turn_controller_unit (
  input  logic       clk,
  input  logic       rst_n,
  hptc_cfg_if.sink   cfg_ch,
  hptc_in_if.sink    in_ch,
  hptc_out_if.source out_ch
);
  import hptc_pkg::*;

  // Configuration registers. The user must write them only while the block is
  // idle (not enforced by the block), so every stage reads them directly.
  logic [GAIN_W-1:0] kp_gain_r;
  logic [GAIN_W-1:0] ki_gain_r;
  logic [GAIN_W-1:0] kd_gain_r;
  logic [MAXD_W-1:0] max_drive_r;
  logic [BAND_W-1:0] settle_band_r;
  logic [SETTLE_W-1:0] settle_ticks_r;
  logic [TMO_W-1:0] timeout_ticks_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_gain_r       <= GAIN_W'(196608);
      ki_gain_r       <= '0;
      kd_gain_r       <= GAIN_W'(2949120);
      max_drive_r     <= MAXD_W'(30);
      settle_band_r   <= BAND_W'(3);
      settle_ticks_r  <= SETTLE_W'(3);
      timeout_ticks_r <= TMO_W'(200);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_KP_GAIN:       kp_gain_r       <= cfg_ch.data[GAIN_W-1:0];
        CFG_KI_GAIN:       ki_gain_r       <= cfg_ch.data[GAIN_W-1:0];
        CFG_KD_GAIN:       kd_gain_r       <= cfg_ch.data[GAIN_W-1:0];
        CFG_MAX_DRIVE:     max_drive_r     <= cfg_ch.data[MAXD_W-1:0];
        CFG_SETTLE_BAND:   settle_band_r   <= cfg_ch.data[BAND_W-1:0];
        CFG_SETTLE_TICKS:  settle_ticks_r  <= cfg_ch.data[SETTLE_W-1:0];
        CFG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_ch.data[TMO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline flow control. Each stage loads when it is empty or its content
  // moves on, so bubbles are squeezed out and the input keeps accepting
  // while a finished result waits in the output register, until stages A to D are full.
  logic a_v_r, b_v_r, c_v_r, d_v_r, o_v_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d, rdy_o;

  assign rdy_o = !o_v_r || out_ch.ready;
  assign rdy_d = !d_v_r || rdy_o;
  assign rdy_c = !c_v_r || rdy_d;
  assign rdy_b = !b_v_r || rdy_c;
  assign rdy_a = !a_v_r || rdy_b;
  assign in_ch.ready = rdy_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (rdy_a) a_v_r <= in_ch.valid;
      if (rdy_b) b_v_r <= a_v_r;
      if (rdy_c) c_v_r <= b_v_r;
      if (rdy_d) d_v_r <= c_v_r;
      if (rdy_o) o_v_r <= d_v_r;
    end
  end

  // Stage A: input register, then the reciprocal multiply that gives the
  // number of whole turns in the offset gyro count. The offset is a multiple
  // of 360, so the remainder equals the wrapped heading. The estimate is exact
  // over the whole 17-bit range, so no correction step is needed.
  logic                       a_action_r;
  logic signed [GYRO_W-1:0]   a_gyro_r;
  logic signed [TARGET_W-1:0] a_target_r;
  logic [UOFS_W-1:0]          a_ofs;
  logic [2*UOFS_W-1:0]        a_recip_prod;

  always_ff @(posedge clk) begin
    if (rdy_a && in_ch.valid) begin
      a_action_r <= in_ch.action;
      a_gyro_r   <= in_ch.raw_gyro;
      a_target_r <= in_ch.target_heading;
    end
  end

  assign a_ofs        = {a_gyro_r[GYRO_W-1], a_gyro_r} + UOFS_W'(GYRO_OFS);
  assign a_recip_prod = a_ofs * UOFS_W'(RECIP);

  // Stage B: remainder, turn error, and the turn state update.
  logic                       b_action_r;
  logic [UOFS_W-1:0]          b_ofs_r;
  logic [QUOT_W-1:0]          b_quot_r;
  logic signed [TARGET_W-1:0] b_target_r;

  always_ff @(posedge clk) begin
    if (rdy_b && a_v_r) begin
      b_action_r <= a_action_r;
      b_ofs_r    <= a_ofs;
      b_quot_r   <= a_recip_prod[RECIP_SHIFT +: QUOT_W];
      b_target_r <= a_target_r;
    end
  end

  logic [UOFS_W-1:0]    b_q360;
  logic [HEADING_W-1:0] b_heading;
  logic signed [ERR_W:0] b_err_raw;
  logic signed [ERR_W:0] b_err_fold;
  logic signed [ERR_W-1:0] b_err;
  logic signed [DERIV_W-1:0] b_deriv;
  logic [ERR_W-1:0] b_mag;
  logic signed [INTEGRAL_WIDTH:0] b_isum;
  logic signed [INTEGRAL_WIDTH-1:0] b_isat;
  logic signed [INTEGRAL_WIDTH-1:0] b_iupd;
  logic in_band;

  // Turn state.
  logic signed [ERR_W-1:0]          prev_err_r, prev_err_nxt;
  logic signed [INTEGRAL_WIDTH-1:0] integ_r, integ_nxt;
  logic [WARM_W-1:0]   warm_r, warm_nxt, warm_inc;
  logic [SETTLE_W-1:0] settle_r, settle_nxt, settle_inc;
  logic [TMO_W-1:0]    tmo_r, tmo_nxt, tmo_inc;
  res_ctrl_t           b_ctl;

  always_comb begin
    // 360 * quotient as shifts: 256 + 64 + 32 + 8.
    b_q360 = UOFS_W'({b_quot_r, 8'b0}) + UOFS_W'({b_quot_r, 6'b0})
             + UOFS_W'({b_quot_r, 5'b0}) + UOFS_W'({b_quot_r, 3'b0});
    b_heading = HEADING_W'(b_ofs_r - b_q360);
    b_err_raw = $signed({b_target_r[TARGET_W-1], b_target_r})
                - $signed({2'b00, b_heading});
    // A single fold toward the short way round.
    if (b_err_raw > (ERR_W+1)'(180)) begin
      b_err_fold = b_err_raw - (ERR_W+1)'(360);
    end else if (b_err_raw < -(ERR_W+1)'(180)) begin
      b_err_fold = b_err_raw + (ERR_W+1)'(360);
    end else begin
      b_err_fold = b_err_raw;
    end
    b_err   = b_err_fold[ERR_W-1:0];
    b_deriv = $signed({b_err[ERR_W-1], b_err}) - $signed({prev_err_r[ERR_W-1], prev_err_r});
    b_mag   = b_err[ERR_W-1] ? ERR_W'(-b_err) : ERR_W'(b_err);
    in_band = b_mag < {{(ERR_W-BAND_W){1'b0}}, settle_band_r};

    // Saturating integral: overflow shows as a mismatch of the top two bits.
    b_isum = $signed({integ_r[INTEGRAL_WIDTH-1], integ_r}) + (INTEGRAL_WIDTH+1)'(b_err);
    if (b_isum[INTEGRAL_WIDTH] != b_isum[INTEGRAL_WIDTH-1]) begin
      b_isat = b_isum[INTEGRAL_WIDTH] ? $signed({1'b1, {(INTEGRAL_WIDTH-1){1'b0}}})
                                      : $signed({1'b0, {(INTEGRAL_WIDTH-1){1'b1}}});
    end else begin
      b_isat = b_isum[INTEGRAL_WIDTH-1:0];
    end
    b_iupd = (ki_gain_r != '0) ? b_isat : integ_r;

    warm_inc   = (warm_r != {WARM_W{1'b1}}) ? warm_r + WARM_W'(1) : warm_r;
    settle_inc = !in_band ? '0 :
                 (settle_r != {SETTLE_W{1'b1}}) ? settle_r + SETTLE_W'(1) : settle_r;
    tmo_inc    = (tmo_r != {TMO_W{1'b1}}) ? tmo_r + TMO_W'(1) : tmo_r;
  end

  // Next turn state and result control for the item in stage B.
  always_comb begin
    prev_err_nxt     = prev_err_r;
    integ_nxt        = integ_r;
    warm_nxt         = warm_r;
    settle_nxt       = settle_r;
    tmo_nxt          = tmo_r;
    b_ctl.zero_drive = 1'b0;
    b_ctl.done       = 1'b0;
    if (!b_action_r) begin
      // A start clears the whole turn and answers with zero drive.
      prev_err_nxt     = '0;
      integ_nxt        = '0;
      warm_nxt         = '0;
      settle_nxt       = '0;
      tmo_nxt          = '0;
      b_ctl.zero_drive = 1'b1;
    end else begin
      prev_err_nxt = b_err;
      integ_nxt    = b_iupd;
      warm_nxt     = warm_inc;
      if (warm_inc <= WARM_W'(2)) begin
        // Warm-up ticks update the PID state only.
        b_ctl.zero_drive = 1'b1;
      end else begin
        settle_nxt = settle_inc;
        if (settle_inc > settle_ticks_r) begin
          b_ctl.zero_drive = 1'b1;
          b_ctl.done       = 1'b1;
        end else if (tmo_inc >= timeout_ticks_r) begin
          // The timeout count restarts so that a running turn reports done
          // again after another full timeout period.
          tmo_nxt          = '0;
          b_ctl.zero_drive = 1'b1;
          b_ctl.done       = 1'b1;
        end else begin
          tmo_nxt = tmo_inc;
        end
      end
    end
  end

  logic ld_c;
  assign ld_c = rdy_c && b_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
      warm_r     <= '0;
      settle_r   <= '0;
      tmo_r      <= '0;
    end else if (ld_c) begin
      prev_err_r <= prev_err_nxt;
      integ_r    <= integ_nxt;
      warm_r     <= warm_nxt;
      settle_r   <= settle_nxt;
      tmo_r      <= tmo_nxt;
    end
  end

  // Stage C: PID operands. The integral operand is the freshly updated one.
  pid_operands_t c_ops_r;
  res_ctrl_t     c_ctl_r;

  always_ff @(posedge clk) begin
    if (ld_c) begin
      c_ops_r.err   <= b_err;
      c_ops_r.deriv <= b_deriv;
      c_ops_r.integ <= integ_nxt;
      c_ctl_r       <= b_ctl;
    end
  end

  // Stage D: products live inside the datapath; the sum and clamp follow.
  res_ctrl_t d_ctl_r;
  logic signed [DRIVE_W-1:0] d_drive;
  logic ld_d;
  assign ld_d = rdy_d && c_v_r;

  always_ff @(posedge clk) begin
    if (ld_d) begin
      d_ctl_r <= c_ctl_r;
    end
  end

  hptc_pid_datapath u_datapath (
    .clk       (clk),
    .load      (ld_d),
    .ops       (c_ops_r),
    .kp_gain   (kp_gain_r),
    .ki_gain   (ki_gain_r),
    .kd_gain   (kd_gain_r),
    .max_drive (max_drive_r),
    .drive     (d_drive)
  );

  // Output register. Left and right motors turn in opposite directions.
  logic signed [DRIVE_W-1:0] o_left_r;
  logic signed [DRIVE_W-1:0] o_right_r;
  logic                      o_done_r;

  always_ff @(posedge clk) begin
    if (rdy_o && d_v_r) begin
      o_left_r  <= d_ctl_r.zero_drive ? '0 : d_drive;
      o_right_r <= d_ctl_r.zero_drive ? '0 : -d_drive;
      o_done_r  <= d_ctl_r.done;
    end
  end

  assign out_ch.valid       = o_v_r;
  assign out_ch.left_drive  = o_left_r;
  assign out_ch.right_drive = o_right_r;
  assign out_ch.done_res    = o_done_r;

endmodule

>>> src/hptc_checker.sv
module hptc_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [hptc_pkg::DRIVE_W-1:0] left_drive,
  input logic signed [hptc_pkg::DRIVE_W-1:0] right_drive,
  input logic                               done_res
);
  import hptc_pkg::*;

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(left_drive)
      && $stable(right_drive) && $stable(done_res))
    else $error("result changed while stalled");

  a_opposite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> right_drive == -left_drive)
    else $error("right drive is not the negated left drive");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && done_res |-> left_drive == '0)
    else $error("drive not zero on a finished turn");

  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> left_drive <= DRIVE_W'(100) && left_drive >= -DRIVE_W'(100))
    else $error("drive out of motor range");

endmodule

bind heading_pid_turn_controller_unit hptc_checker u_hptc_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .left_drive  (out_ch.left_drive),
  .right_drive (out_ch.right_drive),
  .done_res    (out_ch.done_res)
);
